// ===== rtl/serial_command_motor_controller_core_macros.svh =====
// Assertion macros for the serial command motor controller checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SERIAL_COMMAND_MOTOR_CONTROLLER_CORE_MACROS_SVH
`define SERIAL_COMMAND_MOTOR_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SCMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/scmc_pkg.sv =====
// Shared types, codes and constants of the serial command motor controller.
// Used by every module of the block; depends on nothing.
`default_nettype none

package scmc_pkg;

    // Default sizes.
    localparam int FRAME_DEPTH_DEF = 6;
    localparam int LEVEL_WIDTH_DEF = 11;

    // Fixed widths.
    localparam int COUNT_W = 3;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Operation codes of an input item.
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_WDOG = 2'd1;
    localparam logic [1:0] OP_CTRL = 2'd2;

    // Drive modes.
    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_FWD = 2'd1;
    localparam logic [1:0] MODE_REV = 2'd2;

    // Configuration register indexes (word address).
    localparam logic [1:0] REG_WDOG_LIMIT  = 2'd0;
    localparam logic [1:0] REG_DAC_LIMIT   = 2'd1;
    localparam logic [1:0] REG_MOTOR_LIMIT = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] WDOG_LIMIT_RST  = 8'd50;
    localparam logic [7:0] DAC_LIMIT_RST   = 8'd160;
    localparam logic [9:0] MOTOR_LIMIT_RST = 10'd500;

    localparam logic [COUNT_W-1:0] FRAME_LENGTH_RST = 3'd4;

    // Special bytes and limits.
    localparam logic [7:0] ABORT_BYTE = 8'h78;  // 'x'
    localparam logic [8:0] ASCII_ZERO = 9'd48;
    localparam logic [9:0] DUTY_MAX   = 10'd1000;

    // Command codes.
    localparam logic [7:0] CMD_A = 8'h61;
    localparam logic [7:0] CMD_B = 8'h62;
    localparam logic [7:0] CMD_C = 8'h63;
    localparam logic [7:0] CMD_D = 8'h64;
    localparam logic [7:0] CMD_E = 8'h65;
    localparam logic [7:0] CMD_F = 8'h66;
    localparam logic [7:0] CMD_G = 8'h67;
    localparam logic [7:0] CMD_I = 8'h69;
    localparam logic [7:0] CMD_J = 8'h6A;
    localparam logic [7:0] CMD_K = 8'h6B;
    localparam logic [7:0] CMD_M = 8'h6D;
    localparam logic [7:0] CMD_N = 8'h6E;
    localparam logic [7:0] CMD_O = 8'h6F;
    localparam logic [7:0] CMD_P = 8'h70;
    localparam logic [7:0] CMD_T = 8'h74;
    localparam logic [7:0] CMD_U = 8'h75;
    localparam logic [7:0] CMD_V = 8'h76;
    localparam logic [7:0] CMD_W = 8'h77;

    // Frame event handed from the frame parser to the command executor.
    typedef struct packed {
        logic       done;
        logic       aborted;
        logic       timeout;
        logic [7:0] code;
        logic [7:0] digit1;
        logic [7:0] digit2;
        logic [7:0] digit3;
    } t_frame_evt;

    // Frame length opened by a command byte; zero for a byte that opens nothing.
    function automatic logic [COUNT_W-1:0] length_of(input logic [7:0] c);
        logic [COUNT_W-1:0] len;
        unique case (c)
            CMD_C, CMD_E, CMD_N, CMD_O, CMD_P, CMD_I, CMD_J,
            CMD_K, CMD_T, CMD_U, CMD_W, CMD_V, CMD_M: len = 3'd1;
            CMD_B, CMD_D, CMD_G:                      len = 3'd2;
            CMD_A:                                    len = 3'd4;
            CMD_F:                                    len = 3'd6;
            default:                                  len = 3'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/serial_command_motor_controller_core.sv =====
// Serial command motor controller. One item (a received byte, a watchdog tick or
// a control tick) is taken per clock into the input register unless it is stalled;
// its result passes into the result register, with all of the item's work done in the
// single logic stage between the two registers. A stalled result holds the result
// register, and the input register still takes one more item. The
// APB port holds the watchdog, DAC and motor limits at byte addresses 0, 4, 8;
// change them only while no item is in flight.
// Depends on scmc_pkg, scmc_frame, scmc_exec and scmc_motor.
`default_nettype none

module serial_command_motor_controller_core #(
    parameter int FRAME_DEPTH = scmc_pkg::FRAME_DEPTH_DEF,
    parameter int LEVEL_WIDTH = scmc_pkg::LEVEL_WIDTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Configuration port.
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [scmc_pkg::PADDR_W-1:0]  paddr,
    input  wire [scmc_pkg::PDATA_W-1:0]  pwdata,
    output logic [scmc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    // Input channel.
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire [1:0]                    i_operation,
    input  wire [7:0]                    i_rx_byte,
    // Output channel.
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [5:0]                   o_pin_states,
    output logic [7:0]                   o_dac_value,
    output logic                         o_dac_write,
    output logic [9:0]                   o_pwm_forward,
    output logic [9:0]                   o_pwm_reverse,
    output logic [1:0]                   o_drive_mode,
    output logic                         o_frame_done,
    output logic [7:0]                   o_command_code,
    output logic                         o_frame_aborted
);

    logic [7:0] r_wdog_limit;
    logic [7:0] r_dac_limit;
    logic [9:0] r_motor_limit;

    logic       r_in_valid;
    logic [1:0] r_op;
    logic [7:0] r_byte;

    logic       advance;
    logic       fire;
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    scmc_pkg::t_frame_evt        evt;
    logic [5:0]                  pins;
    logic [7:0]                  dac;
    logic                        dac_wr;
    logic signed [LEVEL_WIDTH-1:0] target;
    logic [9:0]                  pwm_fwd, pwm_rev;
    logic [1:0]                  mode;

    // Configuration registers.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wdog_limit  <= scmc_pkg::WDOG_LIMIT_RST;
            r_dac_limit   <= scmc_pkg::DAC_LIMIT_RST;
            r_motor_limit <= scmc_pkg::MOTOR_LIMIT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                scmc_pkg::REG_WDOG_LIMIT:  r_wdog_limit  <= pwdata[7:0];
                scmc_pkg::REG_DAC_LIMIT:   r_dac_limit   <= pwdata[7:0];
                scmc_pkg::REG_MOTOR_LIMIT: r_motor_limit <= pwdata[9:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            scmc_pkg::REG_WDOG_LIMIT:  prdata = 32'(r_wdog_limit);
            scmc_pkg::REG_DAC_LIMIT:   prdata = 32'(r_dac_limit);
            scmc_pkg::REG_MOTOR_LIMIT: prdata = 32'(r_motor_limit);
            default:                   prdata = '0;
        endcase
    end

    // Input register; it moves on whenever the result register can take a result.
    assign advance    = !o_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_op   <= i_operation;
            r_byte <= i_rx_byte;
        end
    end

    // Item processing.
    scmc_frame #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_op         (r_op),
        .i_byte       (r_byte),
        .i_wdog_limit (r_wdog_limit),
        .o_evt        (evt)
    );

    scmc_exec #(
        .LEVEL_WIDTH (LEVEL_WIDTH)
    ) u_exec (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_op          (r_op),
        .i_evt         (evt),
        .i_dac_limit   (r_dac_limit),
        .i_motor_limit (r_motor_limit),
        .o_pins        (pins),
        .o_dac         (dac),
        .o_dac_write   (dac_wr),
        .o_target      (target)
    );

    scmc_motor #(
        .LEVEL_WIDTH (LEVEL_WIDTH)
    ) u_motor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_op          (r_op),
        .i_target      (target),
        .o_pwm_forward (pwm_fwd),
        .o_pwm_reverse (pwm_rev),
        .o_mode        (mode)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (advance) begin
            o_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            o_pin_states    <= pins;
            o_dac_value     <= dac;
            o_dac_write     <= dac_wr;
            o_pwm_forward   <= pwm_fwd;
            o_pwm_reverse   <= pwm_rev;
            o_drive_mode    <= mode;
            o_frame_done    <= evt.done;
            o_command_code  <= evt.code;
            o_frame_aborted <= evt.aborted;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scmc_frame.sv =====
// Frame parser and watchdog: opens, fills, completes and aborts command frames.
// Uses scmc_pkg for codes, frame lengths and the frame event type.
`default_nettype none

module scmc_frame #(
    parameter int FRAME_DEPTH = scmc_pkg::FRAME_DEPTH_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_fire,
    input  wire [1:0]             i_op,
    input  wire [7:0]             i_byte,
    input  wire [7:0]             i_wdog_limit,
    output scmc_pkg::t_frame_evt  o_evt
);

    localparam int CW = scmc_pkg::COUNT_W;

    logic          r_active, n_active;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_length, n_length;
    logic [7:0]    r_wd, n_wd;
    logic [7:0]    r_store [FRAME_DEPTH];

    logic          act;
    logic          wr_en;
    logic          done;
    logic          aborted;
    logic          timeout;
    logic [CW-1:0] open_len;
    logic [CW-1:0] cnt_inc;
    logic [7:0]    wd_inc;
    logic [7:0]    eff [4];

    assign open_len = scmc_pkg::length_of(i_byte);
    assign cnt_inc  = r_count + 3'd1;
    assign wd_inc   = r_wd + 8'd1;

    // Next frame and watchdog state for the item in hand.
    always_comb begin
        n_active = r_active;
        n_count  = r_count;
        n_length = r_length;
        n_wd     = r_wd;
        act      = r_active;
        wr_en    = 1'b0;
        done     = 1'b0;
        aborted  = 1'b0;
        timeout  = 1'b0;
        if (i_fire) begin
            unique case (i_op)
                scmc_pkg::OP_BYTE: begin
                    n_wd = 8'd0;
                    if (!r_active && open_len != 3'd0) begin
                        n_length = open_len;
                        act      = 1'b1;
                    end
                    if (act) begin
                        wr_en = 1'b1;
                        if (cnt_inc >= n_length) begin
                            act     = 1'b0;
                            n_count = 3'd0;
                            done    = 1'b1;
                        end else begin
                            n_count = cnt_inc;
                        end
                    end
                    // The abort byte wins even over a completing frame.
                    if (i_byte == scmc_pkg::ABORT_BYTE) begin
                        act     = 1'b0;
                        n_count = 3'd0;
                        done    = 1'b0;
                        aborted = 1'b1;
                    end
                    n_active = act;
                end
                scmc_pkg::OP_WDOG: begin
                    n_wd = wd_inc;
                    if (wd_inc >= i_wdog_limit) begin
                        n_wd     = 8'd0;
                        n_active = 1'b0;
                        n_count  = 3'd0;
                        timeout  = 1'b1;
                        aborted  = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Frame bytes as they stand after this item's write.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            eff[k] = (wr_en && r_count == 3'(k)) ? i_byte : r_store[k];
        end
    end

    always_comb begin
        o_evt.done    = done;
        o_evt.aborted = aborted;
        o_evt.timeout = timeout;
        o_evt.code    = done ? eff[0] : 8'd0;
        o_evt.digit1  = eff[1];
        o_evt.digit2  = eff[2];
        o_evt.digit3  = eff[3];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_count  <= '0;
            r_length <= scmc_pkg::FRAME_LENGTH_RST;
            r_wd     <= 8'd0;
        end else begin
            r_active <= n_active;
            r_count  <= n_count;
            r_length <= n_length;
            r_wd     <= n_wd;
        end
    end

    // Frame store, one byte per position.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < FRAME_DEPTH; i++) begin
            if (wr_en && r_count == 3'(i)) begin
                r_store[i] <= i_byte;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scmc_exec.sv =====
// Command executor: output pins, DAC register, motor target and shutdown flag.
// Uses scmc_pkg for command codes and the frame event from scmc_frame.
`default_nettype none

module scmc_exec #(
    parameter int LEVEL_WIDTH = scmc_pkg::LEVEL_WIDTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_fire,
    input  wire [1:0]                    i_op,
    input  scmc_pkg::t_frame_evt         i_evt,
    input  wire [7:0]                    i_dac_limit,
    input  wire [9:0]                    i_motor_limit,
    output logic [5:0]                   o_pins,
    output logic [7:0]                   o_dac,
    output logic                         o_dac_write,
    output logic signed [LEVEL_WIDTH-1:0] o_target
);

    localparam int LW = LEVEL_WIDTH;
    localparam logic signed [LW:0] STEP = (LW+1)'(1);

    logic [5:0]           r_pins, n_pins;
    logic [7:0]           r_dac, n_dac;
    logic                 r_shut, n_shut;
    logic signed [LW-1:0] r_target, n_target;

    logic signed [8:0]  d1, d2, d3;
    logic signed [15:0] dec_sum;
    logic [7:0]         dec_val;
    logic signed [LW:0] t_wide, t_inc, t_dec, lim_pos, lim_neg;

    // Three-digit decimal value, clamped to the DAC limit.
    assign d1      = $signed({1'b0, i_evt.digit1}) - $signed(scmc_pkg::ASCII_ZERO);
    assign d2      = $signed({1'b0, i_evt.digit2}) - $signed(scmc_pkg::ASCII_ZERO);
    assign d3      = $signed({1'b0, i_evt.digit3}) - $signed(scmc_pkg::ASCII_ZERO);
    assign dec_sum = 16'(d3) + 16'(d2) * 16'sd10 + 16'(d1) * 16'sd100;
    assign dec_val = (dec_sum < 16'sd0 || dec_sum > $signed({8'd0, i_dac_limit}))
                     ? i_dac_limit : dec_sum[7:0];

    // Target steps and their saturation bounds.
    assign t_wide  = {r_target[LW-1], r_target};
    assign t_inc   = t_wide + STEP;
    assign t_dec   = t_wide - STEP;
    assign lim_pos = $signed((LW+1)'(i_motor_limit));
    assign lim_neg = -lim_pos;

    always_comb begin
        n_pins      = r_pins;
        n_dac       = r_dac;
        n_shut      = r_shut;
        n_target    = r_target;
        o_dac_write = 1'b0;
        if (i_fire) begin
            unique case (i_op)
                scmc_pkg::OP_BYTE: begin
                    if (i_evt.done) begin
                        unique case (i_evt.code)
                            scmc_pkg::CMD_A: begin
                                n_dac       = dec_val;
                                o_dac_write = 1'b1;
                            end
                            scmc_pkg::CMD_G: begin
                                n_dac       = i_evt.digit1;
                                o_dac_write = 1'b1;
                            end
                            scmc_pkg::CMD_I: n_pins[0] = ~r_pins[0];
                            scmc_pkg::CMD_P: n_pins[0] = 1'b0;
                            // Forward and reverse pins never both on.
                            scmc_pkg::CMD_J: begin
                                if (r_pins[1]) begin
                                    n_pins[1] = 1'b0;
                                end else begin
                                    n_pins[1] = 1'b1;
                                    n_pins[2] = 1'b0;
                                end
                            end
                            scmc_pkg::CMD_K: begin
                                if (r_pins[2]) begin
                                    n_pins[2] = 1'b0;
                                end else begin
                                    n_pins[2] = 1'b1;
                                    n_pins[1] = 1'b0;
                                end
                            end
                            scmc_pkg::CMD_M: begin
                                n_pins[1] = ~r_pins[1];
                                n_pins[2] = r_pins[1];
                            end
                            scmc_pkg::CMD_T: n_pins[3] = ~r_pins[3];
                            scmc_pkg::CMD_U: n_pins[4] = ~r_pins[4];
                            scmc_pkg::CMD_W: n_pins[5] = ~r_pins[5];
                            scmc_pkg::CMD_N: begin
                                n_target = (t_inc > lim_pos) ? lim_pos[LW-1:0] : t_inc[LW-1:0];
                            end
                            scmc_pkg::CMD_O: begin
                                n_target = (t_dec < lim_neg) ? lim_neg[LW-1:0] : t_dec[LW-1:0];
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                scmc_pkg::OP_WDOG: begin
                    if (i_evt.timeout) begin
                        n_shut = 1'b1;
                    end
                end
                scmc_pkg::OP_CTRL: begin
                    // Anti-spin: pin 1 on forces pin 6 off, then the pending shutdown.
                    if (r_pins[0]) begin
                        n_pins[5] = 1'b0;
                    end
                    if (r_shut) begin
                        n_shut    = 1'b0;
                        n_pins[1] = 1'b0;
                        n_pins[2] = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_pins   = n_pins;
    assign o_dac    = n_dac;
    assign o_target = r_target;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pins   <= 6'd0;
            r_dac    <= 8'd0;
            r_shut   <= 1'b0;
            r_target <= '0;
        end else begin
            r_pins   <= n_pins;
            r_dac    <= n_dac;
            r_shut   <= n_shut;
            r_target <= n_target;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scmc_motor.sv =====
// Motor ramp: steps the motor level toward the target and derives the duties.
// Uses scmc_pkg for operation and drive mode codes.
`default_nettype none

module scmc_motor #(
    parameter int LEVEL_WIDTH = scmc_pkg::LEVEL_WIDTH_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_fire,
    input  wire [1:0]                     i_op,
    input  wire signed [LEVEL_WIDTH-1:0]  i_target,
    output logic [9:0]                    o_pwm_forward,
    output logic [9:0]                    o_pwm_reverse,
    output logic [1:0]                    o_mode
);

    localparam int LW = LEVEL_WIDTH;
    localparam logic signed [LW-1:0] ONE     = LW'(1);
    localparam logic signed [LW-1:0] NEG_ONE = -ONE;
    localparam logic signed [LW:0]   DMAX    = (LW+1)'(scmc_pkg::DUTY_MAX);

    logic signed [LW-1:0] r_level, n_level;
    logic [1:0]           r_mode, n_mode;
    logic signed [LW:0]   pos, neg;
    logic [9:0]           duty_pos, duty_neg;

    // One ramp step per control tick when the target lies outside -1..1; else drive off.
    always_comb begin
        n_level = r_level;
        n_mode  = r_mode;
        if (i_fire && i_op == scmc_pkg::OP_CTRL) begin
            if (i_target > ONE) begin
                n_mode  = scmc_pkg::MODE_FWD;
                n_level = (r_level < i_target) ? r_level + ONE : r_level - ONE;
            end else if (i_target < NEG_ONE) begin
                n_mode  = scmc_pkg::MODE_REV;
                n_level = (r_level > i_target) ? r_level - ONE : r_level + ONE;
            end else begin
                n_mode  = scmc_pkg::MODE_OFF;
            end
        end
    end

    // Duty saturation to 0..1000 in each direction.
    assign pos = {n_level[LW-1], n_level};
    assign neg = -pos;

    always_comb begin
        if (pos < 0) begin
            duty_pos = 10'd0;
        end else if (pos > DMAX) begin
            duty_pos = scmc_pkg::DUTY_MAX;
        end else begin
            duty_pos = pos[9:0];
        end
        if (neg < 0) begin
            duty_neg = 10'd0;
        end else if (neg > DMAX) begin
            duty_neg = scmc_pkg::DUTY_MAX;
        end else begin
            duty_neg = neg[9:0];
        end
    end

    assign o_pwm_forward = (n_mode == scmc_pkg::MODE_FWD) ? duty_pos : 10'd0;
    assign o_pwm_reverse = (n_mode == scmc_pkg::MODE_REV) ? duty_neg : 10'd0;
    assign o_mode        = n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_mode  <= scmc_pkg::MODE_OFF;
        end else begin
            r_level <= n_level;
            r_mode  <= n_mode;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scmc_checker.sv =====
// Port-level checker for the serial command motor controller, bound to the top.
// Depends on serial_command_motor_controller_core_macros.svh and scmc_pkg.
`default_nettype none

`include "serial_command_motor_controller_core_macros.svh"

module scmc_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          psel,
    input wire                          penable,
    input wire                          pwrite,
    input wire [scmc_pkg::PADDR_W-1:0]  paddr,
    input wire [scmc_pkg::PDATA_W-1:0]  pwdata,
    input wire [scmc_pkg::PDATA_W-1:0]  prdata,
    input wire                          pready,
    input wire                          i_in_valid,
    input wire                          o_in_stall,
    input wire [1:0]                    i_operation,
    input wire [7:0]                    i_rx_byte,
    input wire                          o_out_valid,
    input wire                          i_out_stall,
    input wire [5:0]                    o_pin_states,
    input wire [7:0]                    o_dac_value,
    input wire                          o_dac_write,
    input wire [9:0]                    o_pwm_forward,
    input wire [9:0]                    o_pwm_reverse,
    input wire [1:0]                    o_drive_mode,
    input wire                          o_frame_done,
    input wire [7:0]                    o_command_code,
    input wire                          o_frame_aborted
);

    // A stalled item keeps its payload.
    `SCMC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_pin_states) && $stable(o_dac_value) && $stable(o_pwm_forward) && $stable(o_pwm_reverse) && $stable(o_command_code), "stalled item changed")

    // Only the channel of the current drive mode carries duty.
    `SCMC_ASSERT_NOW(a_pwm_mode, o_out_valid, (o_drive_mode == scmc_pkg::MODE_FWD || o_pwm_forward == 10'd0) && (o_drive_mode == scmc_pkg::MODE_REV || o_pwm_reverse == 10'd0), "duty outside its drive mode")

    // An aborted frame is never executed, and only an executed frame writes the DAC.
    `SCMC_ASSERT_NOW(a_done_abort, o_out_valid && !o_frame_done, o_command_code == 8'd0 && !o_dac_write, "command result without a completed frame")

    `SCMC_ASSERT_NOW(a_excl, o_out_valid, !(o_frame_done && o_frame_aborted), "frame both completed and aborted")

    // Forward and reverse pins are interlocked.
    `SCMC_ASSERT_NOW(a_interlock, o_out_valid, !(o_pin_states[1] && o_pin_states[2]), "forward and reverse pins both on")

endmodule

bind serial_command_motor_controller_core scmc_checker u_scmc_checker (.*);

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for serial_command_motor_controller_core: random and directed
// bytes and ticks, an APB limit writer and a result checker against an in-house model.
// Depends on scmc_pkg and the core RTL only.

module testbench;

    // Operation code that the block must ignore.
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SHOWN_ERRORS  = 10;

    typedef enum logic [1:0] {
        ENTRY_ITEM,
        ENTRY_LIMIT,
        ENTRY_PAUSE
    } t_entry_kind;

    typedef enum logic [1:0] {
        APB_IDLE,
        APB_SETUP,
        APB_ACCESS
    } t_apb_phase;

    typedef struct packed {
        t_entry_kind kind;
        logic [1:0]  op;
        logic [7:0]  data;
        logic [2:0]  gap;
        logic [1:0]  reg_index;
        logic [31:0] value;
    } t_stim_entry;

    typedef struct packed {
        logic [5:0] pins;
        logic [7:0] dac;
        logic       dac_wr;
        logic [9:0] fwd;
        logic [9:0] rev;
        logic [1:0] mode;
        logic       done;
        logic [7:0] code;
        logic       aborted;
    } t_ctl_report;

    // Clock, reset and block ports.
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [scmc_pkg::PADDR_W-1:0]  paddr = '0;
    logic [scmc_pkg::PDATA_W-1:0]  pwdata = '0;
    logic [scmc_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    logic       in_valid = 1'b0;
    logic       o_in_stall;
    logic [1:0] in_op = scmc_pkg::OP_BYTE;
    logic [7:0] in_byte = 8'h00;

    logic       o_out_valid;
    logic       out_stall = 1'b0;
    logic [5:0] o_pin_states;
    logic [7:0] o_dac_value;
    logic       o_dac_write;
    logic [9:0] o_pwm_forward;
    logic [9:0] o_pwm_reverse;
    logic [1:0] o_drive_mode;
    logic       o_frame_done;
    logic [7:0] o_command_code;
    logic       o_frame_aborted;

    serial_command_motor_controller_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (in_op),
        .i_rx_byte       (in_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_pin_states    (o_pin_states),
        .o_dac_value     (o_dac_value),
        .o_dac_write     (o_dac_write),
        .o_pwm_forward   (o_pwm_forward),
        .o_pwm_reverse   (o_pwm_reverse),
        .o_drive_mode    (o_drive_mode),
        .o_frame_done    (o_frame_done),
        .o_command_code  (o_command_code),
        .o_frame_aborted (o_frame_aborted)
    );

    // Stimulus and expectation stores.
    t_stim_entry serial_items[$];
    t_ctl_report expected_reports[$];

    int  queued_items = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  error_count = 0;
    bit  sender_calm = 1'b0;
    bit  receiver_calm = 1'b0;
    int  wd_plan = scmc_pkg::WDOG_LIMIT_RST;

    // Controller model state and its copy of the limits.
    logic [7:0]        wd_cap = scmc_pkg::WDOG_LIMIT_RST;
    logic [7:0]        dac_cap = scmc_pkg::DAC_LIMIT_RST;
    logic [9:0]        motor_cap = scmc_pkg::MOTOR_LIMIT_RST;
    logic              in_frame = 1'b0;
    logic [2:0]        frame_pos = 3'd0;
    logic [2:0]        frame_len = scmc_pkg::FRAME_LENGTH_RST;
    logic [7:0]        frame_bytes [6] = '{default: 8'h00};
    logic [7:0]        wd_ticks = 8'd0;
    logic              shutdown_due = 1'b0;
    logic [5:0]        pin_mask = 6'd0;
    logic [7:0]        dac_level = 8'd0;
    int                motor_goal = 0;
    logic signed [10:0] motor_ramp = 11'sd0;
    logic [1:0]        drive_state = scmc_pkg::MODE_OFF;

    logic [7:0] command_set [18] = '{
        scmc_pkg::CMD_A, scmc_pkg::CMD_B, scmc_pkg::CMD_C, scmc_pkg::CMD_D,
        scmc_pkg::CMD_E, scmc_pkg::CMD_F, scmc_pkg::CMD_G, scmc_pkg::CMD_I,
        scmc_pkg::CMD_J, scmc_pkg::CMD_K, scmc_pkg::CMD_M, scmc_pkg::CMD_N,
        scmc_pkg::CMD_O, scmc_pkg::CMD_P, scmc_pkg::CMD_T, scmc_pkg::CMD_U,
        scmc_pkg::CMD_V, scmc_pkg::CMD_W};
    logic [7:0] long_commands [4] = '{scmc_pkg::CMD_A, scmc_pkg::CMD_B,
                                      scmc_pkg::CMD_G, scmc_pkg::CMD_F};

    // Frame length opened by a command byte, zero for any other byte.
    function automatic logic [2:0] frame_size_of(input logic [7:0] c);
        case (c)
            scmc_pkg::CMD_C, scmc_pkg::CMD_E, scmc_pkg::CMD_N, scmc_pkg::CMD_O,
            scmc_pkg::CMD_P, scmc_pkg::CMD_I, scmc_pkg::CMD_J, scmc_pkg::CMD_K,
            scmc_pkg::CMD_T, scmc_pkg::CMD_U, scmc_pkg::CMD_W, scmc_pkg::CMD_V,
            scmc_pkg::CMD_M:                                    return 3'd1;
            scmc_pkg::CMD_B, scmc_pkg::CMD_D, scmc_pkg::CMD_G: return 3'd2;
            scmc_pkg::CMD_A:                                    return 3'd4;
            scmc_pkg::CMD_F:                                    return 3'd6;
            default:                                            return 3'd0;
        endcase
    endfunction

    function automatic logic [9:0] clamp_duty(input int v);
        if (v < 0) return 10'd0;
        if (v > int'(scmc_pkg::DUTY_MAX)) return scmc_pkg::DUTY_MAX;
        return 10'(v);
    endfunction

    // Carries out the completed frame; returns one when the DAC was written.
    function automatic bit run_command();
        int total;
        bit wrote;
        wrote = 1'b0;
        case (frame_bytes[0])
            scmc_pkg::CMD_A: begin
                total = (int'(frame_bytes[3]) - int'(scmc_pkg::ASCII_ZERO))
                      + (int'(frame_bytes[2]) - int'(scmc_pkg::ASCII_ZERO)) * 10
                      + (int'(frame_bytes[1]) - int'(scmc_pkg::ASCII_ZERO)) * 100;
                if (total < 0 || total > int'(dac_cap)) total = int'(dac_cap);
                dac_level = total[7:0];
                wrote = 1'b1;
            end
            scmc_pkg::CMD_G: begin
                dac_level = frame_bytes[1];
                wrote = 1'b1;
            end
            scmc_pkg::CMD_I: pin_mask[0] = ~pin_mask[0];
            scmc_pkg::CMD_P: pin_mask[0] = 1'b0;
            // Forward and reverse pins never come on together.
            scmc_pkg::CMD_J: begin
                if (pin_mask[1]) begin
                    pin_mask[1] = 1'b0;
                end else begin
                    pin_mask[1] = 1'b1;
                    pin_mask[2] = 1'b0;
                end
            end
            scmc_pkg::CMD_K: begin
                if (pin_mask[2]) begin
                    pin_mask[2] = 1'b0;
                end else begin
                    pin_mask[2] = 1'b1;
                    pin_mask[1] = 1'b0;
                end
            end
            scmc_pkg::CMD_M: begin
                pin_mask[2] = pin_mask[1];
                pin_mask[1] = ~pin_mask[2];
            end
            scmc_pkg::CMD_T: pin_mask[3] = ~pin_mask[3];
            scmc_pkg::CMD_U: pin_mask[4] = ~pin_mask[4];
            scmc_pkg::CMD_W: pin_mask[5] = ~pin_mask[5];
            scmc_pkg::CMD_N: begin
                motor_goal = motor_goal + 1;
                if (motor_goal > int'(motor_cap)) motor_goal = int'(motor_cap);
            end
            scmc_pkg::CMD_O: begin
                motor_goal = motor_goal - 1;
                if (motor_goal < -int'(motor_cap)) motor_goal = -int'(motor_cap);
            end
            default: ;
        endcase
        return wrote;
    endfunction

    // Advances the controller model by one item and returns the report it produces.
    function automatic t_ctl_report advance_controller(input logic [1:0] op,
                                                       input logic [7:0] rx);
        t_ctl_report rep;
        logic [2:0]  size;
        rep = '0;
        case (op)
            scmc_pkg::OP_BYTE: begin
                wd_ticks = 8'd0;
                if (!in_frame) begin
                    size = frame_size_of(rx);
                    if (size != 3'd0) begin
                        frame_len = size;
                        in_frame = 1'b1;
                    end
                end
                if (in_frame) begin
                    if (frame_pos < 3'd6) frame_bytes[frame_pos] = rx;
                    frame_pos = frame_pos + 3'd1;
                    if (frame_pos >= frame_len) begin
                        in_frame = 1'b0;
                        frame_pos = 3'd0;
                        rep.done = 1'b1;
                    end
                end
                // The abort byte wins even over a frame it would have completed.
                if (rx == scmc_pkg::ABORT_BYTE) begin
                    in_frame = 1'b0;
                    frame_pos = 3'd0;
                    rep.done = 1'b0;
                    rep.aborted = 1'b1;
                end
                if (rep.done) begin
                    rep.code = frame_bytes[0];
                    rep.dac_wr = run_command();
                end
            end
            scmc_pkg::OP_WDOG: begin
                wd_ticks = wd_ticks + 8'd1;
                if (wd_ticks >= wd_cap) begin
                    wd_ticks = 8'd0;
                    in_frame = 1'b0;
                    frame_pos = 3'd0;
                    shutdown_due = 1'b1;
                    rep.aborted = 1'b1;
                end
            end
            scmc_pkg::OP_CTRL: begin
                // Pin 1 on forces pin 6 off; a pending shutdown drops forward and reverse.
                if (pin_mask[0]) pin_mask[5] = 1'b0;
                if (shutdown_due) begin
                    shutdown_due = 1'b0;
                    pin_mask[2:1] = 2'b00;
                end
                if (motor_goal > 1) begin
                    motor_ramp = (int'(motor_ramp) < motor_goal) ? motor_ramp + 11'sd1
                                                                 : motor_ramp - 11'sd1;
                    drive_state = scmc_pkg::MODE_FWD;
                end else if (motor_goal < -1) begin
                    motor_ramp = (int'(motor_ramp) > motor_goal) ? motor_ramp - 11'sd1
                                                                 : motor_ramp + 11'sd1;
                    drive_state = scmc_pkg::MODE_REV;
                end else begin
                    drive_state = scmc_pkg::MODE_OFF;
                end
            end
            default: ;
        endcase
        rep.pins = pin_mask;
        rep.dac = dac_level;
        rep.fwd = (drive_state == scmc_pkg::MODE_FWD) ? clamp_duty(int'(motor_ramp)) : 10'd0;
        rep.rev = (drive_state == scmc_pkg::MODE_REV) ? clamp_duty(-int'(motor_ramp)) : 10'd0;
        rep.mode = drive_state;
        return rep;
    endfunction

    function automatic void apply_limit(input logic [1:0] idx, input logic [31:0] val);
        case (idx)
            scmc_pkg::REG_WDOG_LIMIT:  wd_cap = val[7:0];
            scmc_pkg::REG_DAC_LIMIT:   dac_cap = val[7:0];
            scmc_pkg::REG_MOTOR_LIMIT: motor_cap = val[9:0];
            default: ;
        endcase
    endfunction

    // Stimulus builders.
    task automatic queue_item(input logic [1:0] op, input logic [7:0] b);
        t_stim_entry e;
        if ($urandom_range(0, 49) == 0) sender_calm = !sender_calm;
        e = '0;
        e.kind = ENTRY_ITEM;
        e.op = op;
        e.data = b;
        e.gap = sender_calm ? 3'd0 : 3'($urandom_range(0, 5));
        serial_items.push_back(e);
        queued_items++;
    endtask

    task automatic queue_limit(input logic [1:0] idx, input int val);
        t_stim_entry e;
        e = '0;
        e.kind = ENTRY_LIMIT;
        e.reg_index = idx;
        e.value = 32'(val);
        serial_items.push_back(e);
        if (idx == scmc_pkg::REG_WDOG_LIMIT) wd_plan = val;
    endtask

    task automatic queue_pause();
        t_stim_entry e;
        e = '0;
        e.kind = ENTRY_PAUSE;
        serial_items.push_back(e);
    endtask

    task automatic queue_bytes(input string s);
        for (int i = 0; i < s.len(); i++) queue_item(scmc_pkg::OP_BYTE, s[i]);
    endtask

    task automatic queue_ticks(input logic [1:0] op, input int count);
        for (int i = 0; i < count; i++) queue_item(op, 8'($urandom_range(0, 255)));
    endtask

    // Mostly complete frames with random contents, mixed with ticks, noise and broken frames.
    task automatic queue_random_traffic(input int count);
        int         first;
        int         pick;
        int         len;
        int         cut;
        logic [7:0] cmd;
        first = queued_items;
        while (queued_items - first < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                if (pick < 6) cmd = scmc_pkg::CMD_N;
                else if (pick < 12) cmd = scmc_pkg::CMD_O;
                else cmd = command_set[$urandom_range(0, 17)];
                queue_item(scmc_pkg::OP_BYTE, cmd);
                len = frame_size_of(cmd);
                for (int i = 1; i < len; i++) begin
                    if (cmd == scmc_pkg::CMD_A && $urandom_range(0, 99) < 85)
                        queue_item(scmc_pkg::OP_BYTE,
                                   8'(int'(scmc_pkg::ASCII_ZERO) + $urandom_range(0, 9)));
                    else
                        queue_item(scmc_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
                end
            end else if (pick < 70) begin
                queue_ticks(scmc_pkg::OP_CTRL, 1);
            end else if (pick < 84) begin
                queue_ticks(scmc_pkg::OP_WDOG, 1);
            end else if (pick < 91) begin
                queue_item(scmc_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
            end else if (pick < 95) begin
                cmd = long_commands[$urandom_range(0, 3)];
                queue_item(scmc_pkg::OP_BYTE, cmd);
                cut = $urandom_range(0, frame_size_of(cmd) - 2);
                for (int i = 0; i < cut; i++)
                    queue_item(scmc_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
                queue_item(scmc_pkg::OP_BYTE, scmc_pkg::ABORT_BYTE);
            end else if (pick < 97) begin
                queue_ticks(OP_SPARE, 1);
            end else if (wd_plan <= 60) begin
                queue_ticks(scmc_pkg::OP_WDOG, wd_plan);
            end else begin
                queue_ticks(scmc_pkg::OP_WDOG, 1);
            end
        end
    endtask

    // Clock.
    initial begin
        forever #10 clk = ~clk;
    end

    // Input driver and APB writer, fed from the stimulus queue.
    int          wait_left = 0;
    bit          gap_armed = 1'b0;
    int          quiet_left = SETTLE_CYCLES;
    t_apb_phase  apb_phase = APB_IDLE;
    logic [1:0]  limit_index = scmc_pkg::REG_WDOG_LIMIT;
    logic [31:0] limit_value = '0;

    always @(posedge clk) begin
        t_stim_entry head;
        if (!rst_n) begin
            in_valid <= 1'b0;
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
        end else begin
            // The block took the presented item at this edge.
            if (in_valid && !o_in_stall) begin
                expected_reports.push_back(advance_controller(in_op, in_byte));
                items_sent++;
            end
            if (!(in_valid && o_in_stall)) begin
                if (apb_phase == APB_SETUP) begin
                    penable <= 1'b1;
                    in_valid <= 1'b0;
                    apb_phase = APB_ACCESS;
                end else if (apb_phase == APB_ACCESS) begin
                    apply_limit(limit_index, limit_value);
                    psel <= 1'b0;
                    penable <= 1'b0;
                    pwrite <= 1'b0;
                    in_valid <= 1'b0;
                    apb_phase = APB_IDLE;
                end else if (serial_items.size() == 0) begin
                    in_valid <= 1'b0;
                end else begin
                    head = serial_items[0];
                    if (head.kind != ENTRY_ITEM) begin
                        // Hold off until every result is back and the block has settled.
                        in_valid <= 1'b0;
                        if (items_sent != results_seen) begin
                            quiet_left = SETTLE_CYCLES;
                        end else if (quiet_left > 0) begin
                            quiet_left--;
                        end else begin
                            if (head.kind == ENTRY_LIMIT) begin
                                psel <= 1'b1;
                                pwrite <= 1'b1;
                                paddr <= {head.reg_index, 2'b00};
                                pwdata <= head.value;
                                limit_index = head.reg_index;
                                limit_value = head.value;
                                apb_phase = APB_SETUP;
                            end
                            serial_items.delete(0);
                            quiet_left = SETTLE_CYCLES;
                        end
                    end else begin
                        if (!gap_armed) begin
                            wait_left = head.gap;
                            gap_armed = 1'b1;
                        end
                        if (wait_left > 0) begin
                            wait_left--;
                            in_valid <= 1'b0;
                        end else begin
                            in_valid <= 1'b1;
                            in_op <= head.op;
                            in_byte <= head.data;
                            serial_items.delete(0);
                            gap_armed = 1'b0;
                        end
                    end
                end
            end
        end
    end

    // Result monitor with random backpressure.
    int stall_left = 0;

    always @(posedge clk) begin
        t_ctl_report seen;
        t_ctl_report want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                seen.pins = o_pin_states;
                seen.dac = o_dac_value;
                seen.dac_wr = o_dac_write;
                seen.fwd = o_pwm_forward;
                seen.rev = o_pwm_reverse;
                seen.mode = o_drive_mode;
                seen.done = o_frame_done;
                seen.code = o_command_code;
                seen.aborted = o_frame_aborted;
                if (expected_reports.size() == 0) begin
                    error_count++;
                    if (error_count <= SHOWN_ERRORS)
                        $display("unexpected result: pins=%h dac=%h", seen.pins, seen.dac);
                end else begin
                    want = expected_reports.pop_front();
                    if (seen.pins !== want.pins || seen.dac !== want.dac
                            || seen.dac_wr !== want.dac_wr || seen.fwd !== want.fwd
                            || seen.rev !== want.rev || seen.mode !== want.mode
                            || seen.done !== want.done || seen.code !== want.code
                            || seen.aborted !== want.aborted) begin
                        error_count++;
                        if (error_count <= SHOWN_ERRORS) begin
                            $display("mismatch on result %0d", results_seen);
                            $display({"  expected pins=%h dac=%h wr=%b fwd=%0d rev=%0d",
                                      " mode=%0d done=%b code=%h abort=%b"},
                                     want.pins, want.dac, want.dac_wr, want.fwd, want.rev,
                                     want.mode, want.done, want.code, want.aborted);
                            $display({"  actual   pins=%h dac=%h wr=%b fwd=%0d rev=%0d",
                                      " mode=%0d done=%b code=%h abort=%b"},
                                     seen.pins, seen.dac, seen.dac_wr, seen.fwd, seen.rev,
                                     seen.mode, seen.done, seen.code, seen.aborted);
                        end
                    end
                end
                results_seen <= results_seen + 1;
                if ($urandom_range(0, 63) == 0) receiver_calm = !receiver_calm;
                stall_left = receiver_calm ? 0 : $urandom_range(0, 5);
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("status: fail");
        $finish;
    end

    // Stimulus plan, reset and end of run.
    initial begin
        // Directed part at reset limits: pin commands, interlock, anti-spin, DAC and abort.
        queue_bytes("iw");
        queue_ticks(scmc_pkg::OP_CTRL, 1);
        queue_bytes("jkmtupnnn");
        queue_ticks(scmc_pkg::OP_CTRL, 1);
        queue_bytes("a999");
        queue_bytes("a/00");
        queue_item(scmc_pkg::OP_BYTE, scmc_pkg::CMD_G);
        queue_item(scmc_pkg::OP_BYTE, 8'hFF);
        queue_item(scmc_pkg::OP_BYTE, scmc_pkg::CMD_B);
        queue_item(scmc_pkg::OP_BYTE, scmc_pkg::ABORT_BYTE);
        queue_ticks(OP_SPARE, 1);
        queue_random_traffic(260);
        queue_pause();

        // Lowest limits.
        queue_limit(scmc_pkg::REG_WDOG_LIMIT, 1);
        queue_limit(scmc_pkg::REG_DAC_LIMIT, 0);
        queue_limit(scmc_pkg::REG_MOTOR_LIMIT, 1);
        queue_random_traffic(260);

        // Highest limits, with one full watchdog run.
        queue_limit(scmc_pkg::REG_WDOG_LIMIT, 255);
        queue_limit(scmc_pkg::REG_DAC_LIMIT, 255);
        queue_limit(scmc_pkg::REG_MOTOR_LIMIT, 1000);
        queue_random_traffic(140);
        queue_item(scmc_pkg::OP_BYTE, scmc_pkg::CMD_F);
        queue_ticks(scmc_pkg::OP_WDOG, 255);
        queue_random_traffic(140);

        // Motor limit lowered under a running target.
        queue_limit(scmc_pkg::REG_WDOG_LIMIT, $urandom_range(2, 20));
        queue_limit(scmc_pkg::REG_DAC_LIMIT, $urandom_range(0, 255));
        queue_limit(scmc_pkg::REG_MOTOR_LIMIT, 8);
        for (int i = 0; i < 10; i++) queue_item(scmc_pkg::OP_BYTE, scmc_pkg::CMD_N);
        queue_ticks(scmc_pkg::OP_CTRL, 6);
        queue_limit(scmc_pkg::REG_MOTOR_LIMIT, 2);
        queue_ticks(scmc_pkg::OP_CTRL, 3);
        queue_bytes("nnooo");
        queue_ticks(scmc_pkg::OP_CTRL, 4);
        queue_random_traffic(260);

        // Random limits.
        queue_limit(scmc_pkg::REG_WDOG_LIMIT, $urandom_range(1, 255));
        queue_limit(scmc_pkg::REG_DAC_LIMIT, $urandom_range(0, 255));
        queue_limit(scmc_pkg::REG_MOTOR_LIMIT, $urandom_range(1, 1000));
        queue_random_traffic(150);
        queue_pause();
        queue_random_traffic(150);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do begin
            @(negedge clk);
        end while (serial_items.size() != 0 || apb_phase != APB_IDLE || in_valid
                   || expected_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0 && expected_reports.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/scmc_pkg.sv
rtl/scmc_frame.sv
rtl/scmc_exec.sv
rtl/scmc_motor.sv
rtl/serial_command_motor_controller_core.sv
rtl/scmc_checker.sv
dv/testbench.sv
